// ===== hdl/tcsp_pkg.sv =====
package tcsp_pkg;

    // Parse phase of the byte front end
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PASS1  = 2'd1,
        PH_PASS2  = 2'd2
    } t_phase;

    // Record kinds
    localparam logic [2:0] KIND_HEADER      = 3'd0;
    localparam logic [2:0] KIND_SHAPE       = 3'd1;
    localparam logic [2:0] KIND_SHAPE_EMPTY = 3'd2;
    localparam logic [2:0] KIND_MAT         = 3'd3;
    localparam logic [2:0] KIND_MAT_EMPTY   = 3'd4;

    // Byte step codes inside a run
    localparam logic [2:0] STEP_TAG    = 3'd0;
    localparam logic [2:0] STEP_LEN    = 3'd1;
    localparam logic [2:0] STEP_ESC_HI = 3'd2;
    localparam logic [2:0] STEP_ESC_LO = 3'd3;
    // Header byte steps: x lo/hi, y lo/hi, z lo/hi
    localparam logic [2:0] STEP_X_LO   = 3'd0;
    localparam logic [2:0] STEP_X_HI   = 3'd1;
    localparam logic [2:0] STEP_Y_LO   = 3'd2;
    localparam logic [2:0] STEP_Y_HI   = 3'd3;
    localparam logic [2:0] STEP_Z_LO   = 3'd4;
    localparam logic [2:0] STEP_HDR_LAST = 3'd5;

    localparam logic [7:0]  EMPTY_TAG_P1 = 8'h28;
    localparam logic [7:0]  EMPTY_TAG_P2 = 8'h11;
    localparam logic [7:0]  LEN_ESCAPE   = 8'hFF;
    localparam logic [7:0]  SHAPE_MASK   = 8'h38;
    localparam logic [7:0]  ROT_MASK     = 8'hC0;
    localparam logic [15:0] CELLS_RESET  = 16'h4000;

    // Record queue between front end and output stage
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] run_length;
        logic [7:0]  attribute_byte;
        logic [2:0]  shape_kind;
        logic [1:0]  rotation;
        logic        overrun;
        logic        chunk_done;
    } t_record;

endpackage

// ===== hdl/tcsp_front.sv =====
module tcsp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte_value,
    input  logic                 i_take,
    output logic                 o_push,
    output tcsp_pkg::t_record    o_rec
);

    tcsp_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_step, n_step;
    logic [15:0]      r_cells_left, n_cells_left;
    logic [15:0]      r_cells_per_pass;
    logic [7:0]       r_tag;
    logic [7:0]       r_high;
    logic [15:0]      r_pos_x, r_pos_y, r_pos_z;

    logic        w_take;
    logic        w_pass1;
    logic        w_empty;
    logic [15:0] w_len;
    logic        w_over;
    logic [15:0] w_left;
    logic        w_finish;
    logic        w_hdr_done;
    logic        w_cfg_zero;
    logic        w_to_pass2;

    assign w_take     = i_valid && i_take;
    assign w_pass1    = (r_phase == tcsp_pkg::PH_PASS1);
    assign w_empty    = w_pass1 ? (r_tag == tcsp_pkg::EMPTY_TAG_P1)
                                : (r_tag == tcsp_pkg::EMPTY_TAG_P2);
    assign w_cfg_zero = (r_cells_per_pass == 16'd0);

    // Run length: short form or escaped big-endian form
    assign w_len  = (r_step == tcsp_pkg::STEP_ESC_LO) ? {r_high, i_byte_value}
                                                      : {8'h00, i_byte_value};
    assign w_over = (w_len > r_cells_left);
    assign w_left = w_over ? 16'd0 : (r_cells_left - w_len);

    assign w_finish = w_take && (r_phase == tcsp_pkg::PH_PASS1 ||
                                 r_phase == tcsp_pkg::PH_PASS2) &&
                      ((r_step == tcsp_pkg::STEP_LEN && i_byte_value != tcsp_pkg::LEN_ESCAPE)
                       || r_step == tcsp_pkg::STEP_ESC_LO);
    assign w_hdr_done = w_take && (r_phase == tcsp_pkg::PH_HEADER) &&
                        (r_step == tcsp_pkg::STEP_HDR_LAST);
    assign w_to_pass2 = w_pass1 && !w_cfg_zero;

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_step       = r_step;
        n_cells_left = r_cells_left;
        if (w_take) begin
            unique case (r_phase) inside
                tcsp_pkg::PH_HEADER: begin
                    if (r_step == tcsp_pkg::STEP_HDR_LAST) begin
                        n_step = tcsp_pkg::STEP_X_LO;
                        if (!w_cfg_zero) begin
                            n_phase      = tcsp_pkg::PH_PASS1;
                            n_cells_left = r_cells_per_pass;
                        end
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
                tcsp_pkg::PH_PASS1, tcsp_pkg::PH_PASS2: begin
                    case (r_step)
                        tcsp_pkg::STEP_TAG:    n_step = tcsp_pkg::STEP_LEN;
                        tcsp_pkg::STEP_LEN:    n_step = tcsp_pkg::STEP_ESC_HI;
                        tcsp_pkg::STEP_ESC_HI: n_step = tcsp_pkg::STEP_ESC_LO;
                        default:               n_step = tcsp_pkg::STEP_TAG;
                    endcase
                    if (w_finish) begin
                        n_step       = tcsp_pkg::STEP_TAG;
                        n_cells_left = w_left;
                        if (w_left == 16'd0) begin
                            if (w_to_pass2) begin
                                n_phase      = tcsp_pkg::PH_PASS2;
                                n_cells_left = r_cells_per_pass;
                            end else begin
                                n_phase = tcsp_pkg::PH_HEADER;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = tcsp_pkg::PH_HEADER;
                    n_step  = tcsp_pkg::STEP_X_LO;
                end
            endcase
        end
    end

    // Record build
    always_comb begin
        o_push = w_hdr_done || w_finish;
        o_rec  = '0;
        if (w_hdr_done) begin
            o_rec.record_kind = tcsp_pkg::KIND_HEADER;
            o_rec.pos_x       = r_pos_x;
            o_rec.pos_y       = r_pos_y;
            o_rec.pos_z       = {i_byte_value, r_pos_z[7:0]};
            o_rec.chunk_done  = w_cfg_zero;
        end else begin
            if (w_pass1) begin
                o_rec.record_kind = w_empty ? tcsp_pkg::KIND_SHAPE_EMPTY
                                            : tcsp_pkg::KIND_SHAPE;
            end else begin
                o_rec.record_kind = w_empty ? tcsp_pkg::KIND_MAT_EMPTY
                                            : tcsp_pkg::KIND_MAT;
            end
            o_rec.run_length     = w_len;
            o_rec.attribute_byte = w_empty ? 8'h00 : r_tag;
            if (w_pass1 && !w_empty) begin
                o_rec.shape_kind = 3'((r_tag & tcsp_pkg::SHAPE_MASK) >> 3);
                o_rec.rotation   = 2'((r_tag & tcsp_pkg::ROT_MASK) >> 6);
            end
            o_rec.overrun    = w_over;
            o_rec.chunk_done = (w_left == 16'd0) && !w_to_pass2;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= tcsp_pkg::PH_HEADER;
            r_step           <= tcsp_pkg::STEP_X_LO;
            r_cells_left     <= 16'd0;
            r_cells_per_pass <= tcsp_pkg::CELLS_RESET;
        end else begin
            r_phase      <= n_phase;
            r_step       <= n_step;
            r_cells_left <= n_cells_left;
            if (i_cfg_wr_en) begin
                r_cells_per_pass <= i_cfg_wr_data;
            end
        end
    end

    // Held tag, escape high byte and header position bytes
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_phase == tcsp_pkg::PH_HEADER) begin
                case (r_step)
                    tcsp_pkg::STEP_X_LO: r_pos_x[7:0]  <= i_byte_value;
                    tcsp_pkg::STEP_X_HI: r_pos_x[15:8] <= i_byte_value;
                    tcsp_pkg::STEP_Y_LO: r_pos_y[7:0]  <= i_byte_value;
                    tcsp_pkg::STEP_Y_HI: r_pos_y[15:8] <= i_byte_value;
                    tcsp_pkg::STEP_Z_LO: r_pos_z[7:0]  <= i_byte_value;
                    default:             r_pos_z[15:8] <= i_byte_value;
                endcase
            end else if (r_step == tcsp_pkg::STEP_TAG) begin
                r_tag <= i_byte_value;
            end else if (r_step == tcsp_pkg::STEP_ESC_HI) begin
                r_high <= i_byte_value;
            end
        end
    end

    // A pass in progress always has cells to cover
    a_pass_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tcsp_pkg::PH_HEADER) |-> (r_cells_left != 16'd0))
        else $error("pass active with no cells left");

    // Step counter stays inside its phase's range
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step <= tcsp_pkg::STEP_HDR_LAST) &&
        ((r_phase == tcsp_pkg::PH_HEADER) || (r_step <= tcsp_pkg::STEP_ESC_LO)))
        else $error("byte step out of range");

endmodule

// ===== hdl/tcsp_queue.sv =====
module tcsp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcsp_pkg::t_record    i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tcsp_pkg::t_record    o_data
);

    tcsp_pkg::t_record              r_mem [tcsp_pkg::QDEPTH];
    logic [tcsp_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [tcsp_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == tcsp_pkg::QCNT_W'(tcsp_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer wrap at the queue depth
    function automatic logic [tcsp_pkg::QPTR_W-1:0] f_inc(
        input logic [tcsp_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == tcsp_pkg::QPTR_W'(tcsp_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return ptr + tcsp_pkg::QPTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + tcsp_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - tcsp_pkg::QCNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("record pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("record popped from empty queue");

endmodule

// ===== hdl/tcsp_out.sv =====
module tcsp_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  tcsp_pkg::t_record    i_data,
    output logic                 o_pop,
    input  logic                 i_ready,
    output logic                 o_valid,
    output tcsp_pkg::t_record    o_rec
);

    logic              r_valid;
    tcsp_pkg::t_record r_rec;

    // Refill whenever the register is empty or its record is taken
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_data;
        end
    end

    // A held record is not replaced before its transfer
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !o_pop)
        else $error("output record overwritten while stalled");

endmodule

// ===== hdl/terrain_chunk_segment_parser.sv =====
// Terrain chunk segment parser.
// Input channel: one stream byte per transfer on i_byte_value (i_valid/o_ready).
// Each chunk is a six-byte little-endian x/y/z header followed by two
// run-length passes (tag byte, length byte, 0xFF escapes to a big-endian
// 16-bit length) that each cover cells_per_pass cells.
// Output channel: one record per header or run (o_valid/i_ready), carrying
// kind, position, run length, tag attributes, overrun and chunk-done flags.
// Config: i_cfg_wr_en/i_cfg_wr_data writes cells_per_pass; write only when idle.
// Throughput: one byte per cycle, sustained, as long as the receiver keeps up.
// Record path: the front parser builds a record from the byte that completes it,
// the two-entry record queue stores it, and the output register drives o_valid.
// Stall: while i_ready is low the output register holds its record; the queue
// absorbs two more records, and o_ready drops once the queue is full. Bytes
// that complete no record are still held back then.
// Reset (synchronous, i_rst_n low): parser returns to the header phase,
// queue and output register empty, cells_per_pass = 0x4000.
module terrain_chunk_segment_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_record_kind,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic [15:0]        o_run_length,
    output logic [7:0]         o_attribute_byte,
    output logic [2:0]         o_shape_kind,
    output logic [1:0]         o_rotation,
    output logic               o_overrun,
    output logic               o_chunk_done
);

    logic              w_full, w_empty, w_push, w_pop;
    tcsp_pkg::t_record w_front_rec, w_queue_rec, w_out_rec;

    assign o_ready = !w_full;

    // Byte parser
    tcsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .i_byte_value  (i_byte_value),
        .i_take        (o_ready),
        .o_push        (w_push),
        .o_rec         (w_front_rec)
    );

    // Record queue
    tcsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_queue_rec)
    );

    // Output register
    tcsp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_queue_rec),
        .o_pop   (w_pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_rec   (w_out_rec)
    );

    assign o_record_kind    = w_out_rec.record_kind;
    assign o_pos_x          = $signed(w_out_rec.pos_x);
    assign o_pos_y          = $signed(w_out_rec.pos_y);
    assign o_pos_z          = $signed(w_out_rec.pos_z);
    assign o_run_length     = w_out_rec.run_length;
    assign o_attribute_byte = w_out_rec.attribute_byte;
    assign o_shape_kind     = w_out_rec.shape_kind;
    assign o_rotation       = w_out_rec.rotation;
    assign o_overrun        = w_out_rec.overrun;
    assign o_chunk_done     = w_out_rec.chunk_done;

endmodule
